/* rtl/wmce_pkg.sv */
// Shared constants, types and codes for the weighted MAX-SAT clause energy block.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
`default_nettype none

package wmce_pkg;

    // Table sizes.
    localparam int MAX_CLAUSES  = 256;
    localparam int MAX_LITERALS = 16;
    localparam int MAX_VARS     = 64;

    // Field widths fixed by the beat format.
    localparam int CLS_W    = 8;
    localparam int SLOT_W   = 4;
    localparam int LIT_W    = 8;
    localparam int WGT_W    = 32;
    localparam int LEN_W    = 5;
    localparam int ASG_W    = 64;
    localparam int KIND_W   = 2;
    localparam int NUMC_W   = 9;
    localparam int ENERGY_W = 40;

    // Derived widths.
    localparam int ADDR_W = (MAX_CLAUSES > 1) ? $clog2(MAX_CLAUSES) : 1;
    localparam int CNT_W  = $clog2(MAX_CLAUSES + 1);
    localparam int VIDX_W = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;

    // Input tdata layout, lowest bit first.
    localparam int IN_CLS_LSB  = 0;
    localparam int IN_SLOT_LSB = IN_CLS_LSB + CLS_W;
    localparam int IN_LIT_LSB  = IN_SLOT_LSB + SLOT_W;
    localparam int IN_WGT_LSB  = IN_LIT_LSB + LIT_W;
    localparam int IN_LEN_LSB  = IN_WGT_LSB + WGT_W;
    localparam int IN_ASG_LSB  = IN_LEN_LSB + LEN_W;
    localparam int IN_USED_W   = IN_ASG_LSB + ASG_W;
    localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((ENERGY_W + 7) / 8) * 8;

    // One clause row: every literal slot of one clause.
    typedef logic [MAX_LITERALS-1:0][LIT_W-1:0] t_row;

    // Item kinds carried in tuser.
    typedef enum logic [KIND_W-1:0] {
        KIND_WR_LIT  = 2'd0,
        KIND_WR_WGT  = 2'd1,
        KIND_EVAL    = 2'd2,
        KIND_UNUSED  = 2'd3
    } t_kind;

endpackage

`default_nettype wire

/* rtl/weighted_maxsat_clause_energy_top.sv */
// Weighted MAX-SAT clause energy block: clause tables, evaluation sequencer and stream ports.
// Depends on wmce_pkg and wmce_clause_chk.
// A table-write beat is acknowledged on the output in the cycle after it is taken. An
// evaluate beat walks min(num_clauses, MAX_CLAUSES) clause rows in turn through the single
// row read port and the one accumulator; input is not ready until its result is loaded.
// Reset (synchronous, active low) clears the sequencer, the output register and num_clauses;
// the clause tables are not cleared and must be written before they are evaluated.
`default_nettype none

module weighted_maxsat_clause_energy_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,

    // Configuration: num_clauses.
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [wmce_pkg::NUMC_W-1:0]       i_cfg_wr_data,

    // Input stream.
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // tdata, lowest bit first: clause_index[7:0], slot[11:8], literal[19:12],
    // weight[51:20], length[56:52], assignment[120:57], zero fill to 128 bits.
    input  wire logic [wmce_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // tuser: kind[1:0].
    input  wire logic [wmce_pkg::KIND_W-1:0]       i_s_axis_tuser,

    // Output stream.
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // tdata: energy[39:0].
    output logic [wmce_pkg::OUT_TDATA_W-1:0]       o_m_axis_tdata,
    // tuser: is_energy[0].
    output logic                                   o_m_axis_tuser
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_OUT
    } t_state;

    // Input beat fields.
    logic [wmce_pkg::CLS_W-1:0]  in_cls;
    logic [wmce_pkg::SLOT_W-1:0] in_slot;
    logic [wmce_pkg::LIT_W-1:0]  in_lit;
    logic [wmce_pkg::WGT_W-1:0]  in_wgt;
    logic [wmce_pkg::LEN_W-1:0]  in_len;
    logic [wmce_pkg::ASG_W-1:0]  in_asg;
    wmce_pkg::t_kind             in_kind;

    assign in_cls  = i_s_axis_tdata[wmce_pkg::IN_CLS_LSB  +: wmce_pkg::CLS_W];
    assign in_slot = i_s_axis_tdata[wmce_pkg::IN_SLOT_LSB +: wmce_pkg::SLOT_W];
    assign in_lit  = i_s_axis_tdata[wmce_pkg::IN_LIT_LSB  +: wmce_pkg::LIT_W];
    assign in_wgt  = i_s_axis_tdata[wmce_pkg::IN_WGT_LSB  +: wmce_pkg::WGT_W];
    assign in_len  = i_s_axis_tdata[wmce_pkg::IN_LEN_LSB  +: wmce_pkg::LEN_W];
    assign in_asg  = i_s_axis_tdata[wmce_pkg::IN_ASG_LSB  +: wmce_pkg::ASG_W];
    assign in_kind = wmce_pkg::t_kind'(i_s_axis_tuser);

    // Control and accumulation registers.
    t_state                         r_state;
    logic [wmce_pkg::NUMC_W-1:0]    r_num_clauses;
    logic [wmce_pkg::CNT_W-1:0]     r_cnt;
    logic [wmce_pkg::CNT_W-1:0]     r_lim;
    logic                           r_v1;
    logic                           r_v2;
    logic [wmce_pkg::WGT_W-1:0]     r_add;
    logic [wmce_pkg::ENERGY_W-1:0]  r_acc;
    logic [wmce_pkg::ASG_W-1:0]     r_assign;
    logic                           r_out_valid;
    logic                           r_out_is_energy;
    logic [wmce_pkg::ENERGY_W-1:0]  r_out_energy;

    // Clause tables. Literals are kept one clause per row so that a whole
    // clause is read at once; a literal write touches one byte lane.
    wmce_pkg::t_row                                   lit_mem [wmce_pkg::MAX_CLAUSES];
    logic [wmce_pkg::WGT_W+wmce_pkg::LEN_W-1:0]       wl_mem  [wmce_pkg::MAX_CLAUSES];
    wmce_pkg::t_row                                   r_row;
    logic [wmce_pkg::WGT_W+wmce_pkg::LEN_W-1:0]       r_wl;

    logic                           out_free;
    logic                           out_load;
    logic                           in_accept;
    logic                           issue;
    logic                           row_sat;
    logic [wmce_pkg::CNT_W-1:0]     n_lim;
    logic [wmce_pkg::ENERGY_W:0]    n_sum;
    logic [wmce_pkg::ADDR_W-1:0]    wr_addr;
    logic [wmce_pkg::ADDR_W-1:0]    rd_addr;
    logic                           wr_in_range;

    // The output register can take a new beat when it is empty or being drained.
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE) && out_free;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    // The output register is loaded by a write acknowledge or by a finished evaluation.
    assign out_load = ((r_state == ST_IDLE) && in_accept && (in_kind != wmce_pkg::KIND_EVAL))
                      || ((r_state == ST_OUT) && out_free);

    // Clamp the clause count once, when an evaluation starts.
    assign n_lim = (int'(r_num_clauses) > wmce_pkg::MAX_CLAUSES)
                   ? wmce_pkg::CNT_W'(wmce_pkg::MAX_CLAUSES)
                   : wmce_pkg::CNT_W'(r_num_clauses);

    // A new clause row is requested every cycle until all clauses in use are issued.
    assign issue   = (r_state == ST_RUN) && (r_cnt < r_lim);
    assign rd_addr = r_cnt[wmce_pkg::ADDR_W-1:0];

    // Writes beyond the table are dropped but still acknowledged.
    assign wr_in_range = (int'(in_cls) < wmce_pkg::MAX_CLAUSES)
                         && (int'(in_slot) < wmce_pkg::MAX_LITERALS);
    assign wr_addr     = wmce_pkg::ADDR_W'(in_cls);

    always_ff @(posedge i_clk) begin
        if (in_accept && (in_kind == wmce_pkg::KIND_WR_LIT) && wr_in_range) begin
            lit_mem[wr_addr][in_slot] <= in_lit;
        end
        r_row <= lit_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && (in_kind == wmce_pkg::KIND_WR_WGT)
                && (int'(in_cls) < wmce_pkg::MAX_CLAUSES)) begin
            wl_mem[wr_addr] <= {in_len, in_wgt};
        end
        r_wl <= wl_mem[rd_addr];
    end

    wmce_clause_chk u_chk (
        .i_row    (r_row),
        .i_len    (r_wl[wmce_pkg::WGT_W +: wmce_pkg::LEN_W]),
        .i_assign (r_assign),
        .o_sat    (row_sat)
    );

    // Shared accumulator with saturation at the top of the energy range.
    assign n_sum = {1'b0, r_acc} + {{(wmce_pkg::ENERGY_W + 1 - wmce_pkg::WGT_W){1'b0}}, r_add};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_num_clauses   <= '0;
            r_cnt           <= '0;
            r_lim           <= '0;
            r_v1            <= 1'b0;
            r_v2            <= 1'b0;
            r_acc           <= '0;
            r_out_valid     <= 1'b0;
            r_out_is_energy <= 1'b0;
            r_out_energy    <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_num_clauses <= i_cfg_wr_data;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            // Row pipeline: read, check, accumulate.
            r_v1 <= issue;
            r_v2 <= r_v1;
            if (r_v1) begin
                r_add <= row_sat ? '0 : r_wl[wmce_pkg::WGT_W-1:0];
            end
            if (r_v2) begin
                r_acc <= n_sum[wmce_pkg::ENERGY_W]
                         ? {wmce_pkg::ENERGY_W{1'b1}}
                         : n_sum[wmce_pkg::ENERGY_W-1:0];
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        if (in_kind == wmce_pkg::KIND_EVAL) begin
                            r_assign <= in_asg;
                            r_cnt    <= '0;
                            r_lim    <= n_lim;
                            r_acc    <= '0;
                            r_state  <= ST_RUN;
                        end else begin
                            // Table writes and the unused kind are acknowledged at once.
                            r_out_is_energy <= 1'b0;
                            r_out_energy    <= '0;
                        end
                    end
                end
                ST_RUN: begin
                    if (issue) begin
                        r_cnt <= r_cnt + 1'b1;
                    end else if (!r_v1 && !r_v2) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_out_is_energy <= 1'b1;
                        r_out_energy    <= r_acc;
                        r_state         <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_is_energy;
    assign o_m_axis_tdata  = wmce_pkg::OUT_TDATA_W'(r_out_energy);

endmodule

`default_nettype wire

/* rtl/wmce_clause_chk.sv */
// Checks one clause row against an assignment: true when any active literal is satisfied.
// Depends on wmce_pkg.
`default_nettype none

module wmce_clause_chk (
    input  wire wmce_pkg::t_row                  i_row,
    input  wire logic [wmce_pkg::LEN_W-1:0]      i_len,
    input  wire logic [wmce_pkg::ASG_W-1:0]      i_assign,
    output logic                                 o_sat
);

    logic [wmce_pkg::MAX_LITERALS-1:0] lane_sat;

    // Each lane decodes its literal independently; lanes at or beyond the
    // clause length are masked off, which also clamps over-long lengths.
    always_comb begin
        logic [wmce_pkg::LIT_W-1:0] raw;
        logic [wmce_pkg::LIT_W-1:0] var_num;
        logic [wmce_pkg::LIT_W-1:0] var_m1;
        logic                       neg;
        logic                       bit_val;
        for (int j = 0; j < wmce_pkg::MAX_LITERALS; j++) begin
            raw     = i_row[j];
            neg     = raw[wmce_pkg::LIT_W-1];
            var_num = neg ? (~raw + 1'b1) : raw;
            var_m1  = var_num - 1'b1;
            bit_val = i_assign[var_m1[wmce_pkg::VIDX_W-1:0]];
            lane_sat[j] = (j < int'(i_len))
                          && (var_num != '0)
                          && (int'(var_num) <= wmce_pkg::MAX_VARS)
                          && (neg ? !bit_val : bit_val);
        end
    end

    assign o_sat = |lane_sat;

endmodule

`default_nettype wire

/* dv/weighted_maxsat_clause_energy_top_test.sv */
// Self-checking testbench for weighted_maxsat_clause_energy_top: builds weighted clause tables,
// scores assignments against them and checks every result beat against its own energy predictor.
// Depends on wmce_pkg and the block's RTL only.
`default_nettype none

module weighted_maxsat_clause_energy_top_test;

    import wmce_pkg::*;

    // One input beat, its fields as the block sees them.
    typedef struct packed {
        t_kind             kind;
        logic [CLS_W-1:0]  cls;
        logic [SLOT_W-1:0] slot;
        logic [LIT_W-1:0]  lit;
        logic [WGT_W-1:0]  wgt;
        logic [LEN_W-1:0]  len;
        logic [ASG_W-1:0]  asg;
    } t_beat;

    // One result beat.
    typedef struct packed {
        logic                is_energy;
        logic [ENERGY_W-1:0] energy;
    } t_result;

    // Generous ceiling on the whole run, in time units.
    localparam int RUN_LIMIT = 40_000_000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_wr_en   = 1'b0;
    logic [NUMC_W-1:0]     cfg_wr_data = '0;

    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_TDATA_W-1:0] s_tdata  = '0;
    logic [KIND_W-1:0]     s_tuser  = '0;

    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;

    // Beats still to be offered, the beat on the bus, and the results owed by the block.
    t_beat   beats_to_send [$];
    t_beat   cur_beat;
    bit      beat_taken = 1'b0;
    t_result energy_due [$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int mismatch_count = 0;

    // Predictor copy of the clause tables and of the num_clauses register.
    logic [LIT_W-1:0]  lit_mem    [MAX_CLAUSES*MAX_LITERALS];
    logic [WGT_W-1:0]  weight_mem [MAX_CLAUSES];
    logic [LEN_W-1:0]  length_mem [MAX_CLAUSES];
    logic [NUMC_W-1:0] clauses_in_use = '0;

    // Stimulus bookkeeping: which table entries have been queued for writing so far. It is used
    // to make sure that an evaluation never walks an entry that has not been written yet.
    bit                      gen_defined [MAX_CLAUSES] = '{default: 1'b0};
    logic [MAX_LITERALS-1:0] gen_slots   [MAX_CLAUSES] = '{default: '0};
    int                      gen_len     [MAX_CLAUSES] = '{default: 0};

    // num_clauses for each random phase: mostly small tables, with the extremes mixed in.
    int phase_nums [12] = '{1, 9, 16, 0, 33, 256, 5, 511, 2, 12, 64, 7};

    weighted_maxsat_clause_energy_top u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    always #10 clk = ~clk;

    task automatic report_mismatch(input string what);
        // Keep the log readable if the block is badly broken; every mismatch is still counted.
        if (mismatch_count < 100) begin
            $display("MISMATCH at %0t: %s", $time, what);
        end
        mismatch_count++;
    endtask

    // Sum of the weights of the clauses in use that have no satisfied literal. A literal is a
    // signed variable number; zero or a magnitude above MAX_VARS can never be satisfied. Lengths
    // above MAX_LITERALS are clipped, as is a clause count above MAX_CLAUSES.
    function automatic logic [ENERGY_W-1:0] unsat_weight_sum(logic [ASG_W-1:0] asg);
        logic [ENERGY_W:0] total;
        logic [LIT_W-1:0]  raw;
        int                rows;
        int                width;
        int                mag;
        bit                hit;
        total = '0;
        rows  = (int'(clauses_in_use) > MAX_CLAUSES) ? MAX_CLAUSES : int'(clauses_in_use);
        for (int c = 0; c < rows; c++) begin
            width = (int'(length_mem[c]) > MAX_LITERALS) ? MAX_LITERALS : int'(length_mem[c]);
            hit   = 1'b0;
            for (int s = 0; s < width && !hit; s++) begin
                raw = lit_mem[c*MAX_LITERALS + s];
                mag = raw[LIT_W-1] ? (256 - int'(raw)) : int'(raw);
                if (mag >= 1 && mag <= MAX_VARS) begin
                    hit = raw[LIT_W-1] ? !asg[mag-1] : asg[mag-1];
                end
            end
            if (!hit) begin
                total = total + weight_mem[c];
                // Saturation cannot be reached at these table sizes, but the block promises it.
                if (total > {1'b0, {ENERGY_W{1'b1}}}) begin
                    total = {1'b0, {ENERGY_W{1'b1}}};
                end
            end
        end
        return total[ENERGY_W-1:0];
    endfunction

    // Update the predicted tables with an accepted beat and queue the result it owes.
    task automatic absorb_beat(input t_beat b);
        t_result r;
        r = '0;
        case (b.kind)
            KIND_WR_LIT: begin
                lit_mem[int'(b.cls)*MAX_LITERALS + int'(b.slot)] = b.lit;
            end
            KIND_WR_WGT: begin
                weight_mem[b.cls] = b.wgt;
                length_mem[b.cls] = b.len;
            end
            KIND_EVAL: begin
                r.is_energy = 1'b1;
                r.energy    = unsat_weight_sum(b.asg);
            end
            default: begin
                // The spare kind changes nothing and is simply acknowledged.
            end
        endcase
        energy_due.push_back(r);
    endtask

    // Input side: a new beat is offered on the falling edge once the previous one has gone.
    always @(negedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || beat_taken) begin
            if (beats_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                cur_beat = beats_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= IN_TDATA_W'({cur_beat.asg, cur_beat.len, cur_beat.wgt,
                                         cur_beat.lit, cur_beat.slot, cur_beat.cls});
                s_tuser  <= cur_beat.kind;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Output side back-pressure, redrawn every cycle.
    always @(negedge clk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Rising edge: check a result beat first, since it can only belong to a beat taken at an
    // earlier edge, then absorb any input beat taken at this edge.
    always @(posedge clk) begin
        t_result want;
        if (rst_n && m_tvalid && m_tready) begin
            if (energy_due.size() == 0) begin
                report_mismatch("result beat arrived with no result outstanding");
            end else begin
                want = energy_due.pop_front();
                if (m_tuser !== want.is_energy) begin
                    report_mismatch($sformatf("is_energy %b, expected %b",
                                              m_tuser, want.is_energy));
                end
                if (m_tdata !== OUT_TDATA_W'(want.energy)) begin
                    report_mismatch($sformatf("energy 0x%h, expected 0x%h",
                                              m_tdata, want.energy));
                end
            end
        end
        beat_taken = rst_n && s_tvalid && s_tready;
        if (beat_taken) begin
            absorb_beat(cur_beat);
        end
    end

    // A beat with every field random; the caller overrides the fields that matter for its kind,
    // so the ignored fields still toggle every bit of tdata.
    function automatic t_beat rand_beat(t_kind k);
        t_beat b;
        b.kind = k;
        b.cls  = CLS_W'($urandom);
        b.slot = SLOT_W'($urandom);
        b.lit  = LIT_W'($urandom);
        b.wgt  = $urandom;
        b.len  = LEN_W'($urandom);
        b.asg  = {$urandom, $urandom};
        return b;
    endfunction

    task automatic send_lit(input int c, input int s, input logic [LIT_W-1:0] v);
        t_beat b;
        b      = rand_beat(KIND_WR_LIT);
        b.cls  = CLS_W'(c);
        b.slot = SLOT_W'(s);
        b.lit  = v;
        gen_slots[c][s] = 1'b1;
        beats_to_send.push_back(b);
    endtask

    task automatic send_weight(input int c, input logic [WGT_W-1:0] w, input int n);
        t_beat b;
        b     = rand_beat(KIND_WR_WGT);
        b.cls = CLS_W'(c);
        b.wgt = w;
        b.len = LEN_W'(n);
        gen_defined[c] = 1'b1;
        gen_len[c]     = n;
        beats_to_send.push_back(b);
    endtask

    task automatic send_eval(input logic [ASG_W-1:0] a);
        t_beat b;
        b     = rand_beat(KIND_EVAL);
        b.asg = a;
        beats_to_send.push_back(b);
    endtask

    task automatic send_spare();
        beats_to_send.push_back(rand_beat(KIND_UNUSED));
    endtask

    // Mostly well-formed literals over all 64 variables, now and then any 8-bit value at all.
    function automatic logic [LIT_W-1:0] rand_literal();
        int v;
        v = $urandom_range(MAX_VARS, 1);
        if ($urandom_range(9) == 0) begin
            return LIT_W'($urandom);
        end
        return $urandom_range(1) ? LIT_W'(v) : LIT_W'(-v);
    endfunction

    function automatic logic [WGT_W-1:0] rand_weight();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return $urandom_range(32'h0004_0000);
            default: return $urandom;
        endcase
    endfunction

    // Short clauses keep unsatisfied clauses common under random assignments.
    function automatic int rand_length();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
            return $urandom_range(4);
        end else if (pick < 90) begin
            return $urandom_range(MAX_LITERALS, 5);
        end
        return $urandom_range(31, MAX_LITERALS + 1);
    endfunction

    function automatic logic [ASG_W-1:0] rand_assignment();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return ASG_W'(1) << $urandom_range(ASG_W-1);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Make clause c safe to evaluate: give it a weight and length if it has none (or a fresh one
    // when asked), then write every literal slot that its clipped length reaches and that is unwritten.
    task automatic ready_clause(input int c, input bit fresh, input bit short_len);
        int n;
        if (fresh || !gen_defined[c]) begin
            send_weight(c, rand_weight(), short_len ? $urandom_range(3) : rand_length());
        end
        n = (gen_len[c] > MAX_LITERALS) ? MAX_LITERALS : gen_len[c];
        for (int s = 0; s < n; s++) begin
            if (!gen_slots[c][s]) begin
                send_lit(c, s, rand_literal());
            end
        end
    endtask

    // Wait until every queued beat has gone in and every owed result has come out.
    task automatic drain();
        while (beats_to_send.size() != 0 || s_tvalid || energy_due.size() != 0) begin
            @(posedge clk);
        end
    endtask

    // Only ever called with the block drained, so no beat can be taken around the write.
    task automatic write_num_clauses(input int v);
        @(negedge clk);
        cfg_wr_en      <= 1'b1;
        cfg_wr_data    <= NUMC_W'(v);
        clauses_in_use =  NUMC_W'(v);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input int num, input int items, input int mode);
        int used;
        int pick;
        int c;
        int cn;
        drain();
        // Idling modes: none, sender idle, receiver stalling, then both together.
        case (mode)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 64; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 64; end
            default: begin src_idle_pct = 21; sink_stall_pct = 21; end
        endcase
        write_num_clauses(num);
        used = (num > MAX_CLAUSES) ? MAX_CLAUSES : num;
        // Bulk definition uses short clauses so that the large tables stay cheap to build.
        for (int k = 0; k < used; k++) begin
            ready_clause(k, 1'b0, 1'b1);
        end
        for (int i = 0; i < items; i++) begin
            pick = $urandom_range(99);
            c    = (used > 0) ? $urandom_range(used - 1) : $urandom_range(MAX_CLAUSES - 1);
            if (pick < 55) begin
                send_eval(rand_assignment());
            end else if (pick < 70) begin
                send_lit(c, $urandom_range(MAX_LITERALS - 1), rand_literal());
            end else if (pick < 82) begin
                ready_clause(c, 1'b1, 1'b0);
            end else if (pick < 92) begin
                // Writes anywhere in the table; a clause in use gets a fresh weight and length and stays safe.
                cn = $urandom_range(MAX_CLAUSES - 1);
                if (cn < used) begin
                    ready_clause(cn, 1'b1, 1'b0);
                end else if ($urandom_range(1)) begin
                    send_weight(cn, rand_weight(), rand_length());
                end else begin
                    send_lit(cn, $urandom_range(MAX_LITERALS - 1), rand_literal());
                end
            end else begin
                send_spare();
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. With num_clauses still at its reset value nothing is summed.
        send_eval('1);
        send_spare();
        // Clause 0 is empty, so its full-scale weight always counts.
        send_weight(0, 32'hFFFF_FFFF, 0);
        // Clause 1 uses the lowest and the highest variable, the second one negated.
        send_lit(1, 0, LIT_W'(1));
        send_lit(1, 1, LIT_W'(-64));
        send_weight(1, 32'd1, 2);
        // Clause 2 has the largest length field, clipped to sixteen slots. All slots but the
        // last hold literals that can never be satisfied; the last one holds variable 64.
        for (int s = 0; s < MAX_LITERALS - 1; s++) begin
            send_lit(2, s, (s == 0) ? LIT_W'(0) :
                           (s == 1) ? LIT_W'(8'h80) :
                           (s == 2) ? LIT_W'(8'h7F) :
                           (s % 2)  ? LIT_W'(65 + 4*s) : LIT_W'(-65 - 4*s));
        end
        send_lit(2, MAX_LITERALS - 1, LIT_W'(64));
        send_weight(2, 32'h1234_5678, 31);
        drain();
        write_num_clauses(3);
        send_eval('0);
        send_eval('1);
        send_eval({1'b1, {(ASG_W-1){1'b0}}});
        send_eval(ASG_W'(1));

        // Random part, one phase per table size, rotating through the idling modes. Building
        // the tables adds many write beats of its own, so the random item counts stay modest.
        for (int p = 0; p < 12; p++) begin
            run_phase(phase_nums[p], (phase_nums[p] >= 64) ? 20 : 50, p % 4);
        end

        drain();
        // Wait out the longest evaluation; nothing may turn up after that.
        repeat (MAX_CLAUSES + 40) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // A hang anywhere, including a result that never comes, ends here.
    initial begin
        #(RUN_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
rtl/wmce_pkg.sv
rtl/wmce_clause_chk.sv
rtl/weighted_maxsat_clause_energy_top.sv
dv/weighted_maxsat_clause_energy_top_test.sv
